// File: design/dur_pkg.sv
// Shared types and constants of the dual ultrasonic ranger.
package dur_pkg;

  // Echo width per centimetre, in ticks, and largest valid range
  localparam int US_PER_CM    = 58;
  localparam int MAX_RANGE_CM = 400;

  localparam logic [9:0] NO_ECHO_CM = 10'd999;

  // Trigger pulse shape in ticks
  localparam logic [19:0] TRIG_LOW_TICKS  = 20'd2;
  localparam logic [19:0] TRIG_HIGH_TICKS = 20'd10;

  // Register reset values
  localparam logic [19:0] TIMEOUT_RST  = 20'd30000;
  localparam logic [9:0]  OBSTACLE_RST = 10'd30;
  localparam logic [19:0] GAP_RST      = 20'd10000;
  localparam logic [19:0] INTERVAL_RST = 20'd100000;

  // Register index (paddr[3:2])
  typedef enum logic [1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_OBSTACLE = 2'd1,
    REG_GAP      = 2'd2,
    REG_INTERVAL = 2'd3
  } reg_idx_t;

  // Measurement sequence
  typedef enum logic [3:0] {
    PH_F_LOW   = 4'd0,
    PH_F_HIGH  = 4'd1,
    PH_F_RISE  = 4'd2,
    PH_F_WIDTH = 4'd3,
    PH_GAP     = 4'd4,
    PH_B_LOW   = 4'd5,
    PH_B_HIGH  = 4'd6,
    PH_B_RISE  = 4'd7,
    PH_B_WIDTH = 4'd8,
    PH_IDLE    = 4'd9
  } phase_t;

  typedef struct packed {
    logic [19:0] timeout_us;
    logic [9:0]  obstacle_cm;
    logic [19:0] gap_us;
    logic [19:0] interval_us;
  } cfg_t;

  typedef struct packed {
    logic       trig_front;
    logic       trig_back;
    logic [9:0] front_dist_cm;
    logic [9:0] back_cm;
    logic       front_blocked;
    logic       back_blocked;
    logic       update_done;
  } res_t;

endpackage

// File: design/dur_in_if.sv
// Input channel: one tick of both echo levels per word.
interface dur_in_if;
  logic valid;
  logic ready;
  logic echo_front;
  logic echo_back;

  modport source (output valid, output echo_front, output echo_back, input ready);
  modport sink   (input valid, input echo_front, input echo_back, output ready);
endinterface

// File: design/dur_out_if.sv
// Output channel: trigger levels, distances and flags per word.
interface dur_out_if;
  logic       valid;
  logic       ready;
  logic       trig_front;
  logic       trig_back;
  logic [9:0] front_dist_cm;
  logic [9:0] back_cm;
  logic       front_blocked;
  logic       back_blocked;
  logic       update_done;

  modport source (output valid, output trig_front, output trig_back,
                  output front_dist_cm, output back_cm, output front_blocked,
                  output back_blocked, output update_done, input ready);
  modport sink   (input valid, input trig_front, input trig_back,
                  input front_dist_cm, input back_cm, input front_blocked,
                  input back_blocked, input update_done, output ready);
endinterface

// File: design/dur_cfg.sv
// APB register file of the ranger: timeout, obstacle threshold and pauses.
module dur_cfg
  import dur_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     regs;
  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign cfg    = regs;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.timeout_us  <= TIMEOUT_RST;
      regs.obstacle_cm <= OBSTACLE_RST;
      regs.gap_us      <= GAP_RST;
      regs.interval_us <= INTERVAL_RST;
    end else if (wr) begin
      unique case (idx)
        REG_TIMEOUT:  regs.timeout_us  <= pwdata[19:0];
        REG_OBSTACLE: regs.obstacle_cm <= pwdata[9:0];
        REG_GAP:      regs.gap_us      <= pwdata[19:0];
        REG_INTERVAL: regs.interval_us <= pwdata[19:0];
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_TIMEOUT:  prdata = {12'd0, regs.timeout_us};
      REG_OBSTACLE: prdata = {22'd0, regs.obstacle_cm};
      REG_GAP:      prdata = {12'd0, regs.gap_us};
      REG_INTERVAL: prdata = {12'd0, regs.interval_us};
    endcase
  end

endmodule

// File: design/dur_core.sv
// Ranging sequencer: trigger, echo timing, cm conversion and blocked flags.
module dur_core
  import dur_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic echo_front,
  input  logic echo_back,
  input  cfg_t cfg,
  output res_t res
);

  phase_t      phase, phase_next;
  logic [19:0] tick_count, tick_count_next;
  logic [5:0]  sub_cm_count, sub_cm_count_next;
  logic [8:0]  cm_count, cm_count_next;
  logic [9:0]  front_distance, front_distance_next;
  logic [9:0]  back_distance, back_distance_next;
  logic        front_flag, front_flag_next;
  logic        back_flag, back_flag_next;

  logic        is_back, echo, finish, wrap;
  logic [20:0] tick_inc;
  logic [5:0]  sub_inc;
  logic [9:0]  fin_dist;

  // State registers, stepped once per tick word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_F_LOW;
      tick_count     <= '0;
      sub_cm_count   <= '0;
      cm_count       <= '0;
      front_distance <= NO_ECHO_CM;
      back_distance  <= NO_ECHO_CM;
      front_flag     <= 1'b0;
      back_flag      <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      sub_cm_count   <= sub_cm_count_next;
      cm_count       <= cm_count_next;
      front_distance <= front_distance_next;
      back_distance  <= back_distance_next;
      front_flag     <= front_flag_next;
      back_flag      <= back_flag_next;
    end
  end

  // Next state and result word
  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    sub_cm_count_next   = sub_cm_count;
    cm_count_next       = cm_count;
    front_distance_next = front_distance;
    back_distance_next  = back_distance;
    front_flag_next     = front_flag;
    back_flag_next      = back_flag;
    res.trig_front      = 1'b0;
    res.trig_back       = 1'b0;
    res.update_done     = 1'b0;
    finish              = 1'b0;
    fin_dist            = NO_ECHO_CM;

    is_back  = (phase == PH_B_LOW) || (phase == PH_B_HIGH) ||
               (phase == PH_B_RISE) || (phase == PH_B_WIDTH);
    echo     = is_back ? echo_back : echo_front;
    tick_inc = {1'b0, tick_count} + 21'd1;
    sub_inc  = sub_cm_count + 6'd1;
    wrap     = (sub_inc >= 6'(US_PER_CM));

    unique case (phase)
      PH_GAP: begin
        tick_count_next = tick_inc[19:0];
        if (tick_inc >= {1'b0, cfg.gap_us}) begin
          tick_count_next = '0;
          phase_next      = PH_B_LOW;
        end
      end
      PH_IDLE: begin
        tick_count_next = tick_inc[19:0];
        if (tick_inc >= {1'b0, cfg.interval_us}) begin
          tick_count_next = '0;
          phase_next      = PH_F_LOW;
        end
      end
      PH_F_LOW, PH_B_LOW: begin
        tick_count_next = tick_inc[19:0];
        if (tick_inc >= {1'b0, TRIG_LOW_TICKS}) begin
          tick_count_next = '0;
          phase_next      = is_back ? PH_B_HIGH : PH_F_HIGH;
        end
      end
      PH_F_HIGH, PH_B_HIGH: begin
        res.trig_front  = !is_back;
        res.trig_back   = is_back;
        tick_count_next = tick_inc[19:0];
        if (tick_inc >= {1'b0, TRIG_HIGH_TICKS}) begin
          tick_count_next = '0;
          phase_next      = is_back ? PH_B_RISE : PH_F_RISE;
        end
      end
      PH_F_RISE, PH_B_RISE: begin
        if (echo) begin
          // rising tick is the first tick of the width
          tick_count_next   = 20'd1;
          sub_cm_count_next = 6'd1;
          cm_count_next     = '0;
          phase_next        = is_back ? PH_B_WIDTH : PH_F_WIDTH;
        end else if (tick_count >= cfg.timeout_us) begin
          finish = 1'b1;
        end else begin
          tick_count_next = tick_inc[19:0];
        end
      end
      PH_F_WIDTH, PH_B_WIDTH: begin
        if (echo) begin
          if (tick_count >= cfg.timeout_us) begin
            finish = 1'b1;
          end else begin
            tick_count_next   = tick_inc[19:0];
            sub_cm_count_next = wrap ? 6'd0 : sub_inc;
            if (wrap && (cm_count <= 9'(MAX_RANGE_CM))) begin
              cm_count_next = cm_count + 9'd1;
            end
          end
        end else begin
          finish = 1'b1;
          if ((cm_count != 9'd0) && (cm_count <= 9'(MAX_RANGE_CM))) begin
            fin_dist = {1'b0, cm_count};
          end
        end
      end
      default: begin
        phase_next      = PH_F_LOW;
        tick_count_next = '0;
      end
    endcase

    // Store a finished reading and move on
    if (finish) begin
      tick_count_next   = '0;
      sub_cm_count_next = '0;
      cm_count_next     = '0;
      if (!is_back) begin
        front_distance_next = fin_dist;
        phase_next          = (cfg.gap_us == 20'd0) ? PH_B_LOW : PH_GAP;
      end else begin
        back_distance_next = fin_dist;
        front_flag_next    = (front_distance < cfg.obstacle_cm);
        back_flag_next     = (fin_dist < cfg.obstacle_cm);
        phase_next         = (cfg.interval_us == 20'd0) ? PH_F_LOW : PH_IDLE;
        res.update_done    = 1'b1;
      end
    end

    res.front_dist_cm = front_distance_next;
    res.back_cm       = back_distance_next;
    res.front_blocked = front_flag_next;
    res.back_blocked  = back_flag_next;
  end

`ifndef ASSERT_OFF
  // Update pulse only ends a back measurement
  a_done_back: assert property (@(posedge clk) disable iff (rst)
    advance && res.update_done |-> (phase == PH_B_RISE) || (phase == PH_B_WIDTH))
    else $error("update pulse outside back measurement");

  // Flags change only with an update pulse
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && res.update_done) |=> $stable(front_flag) && $stable(back_flag))
    else $error("blocked flags changed without update");

  // Centimetre counters stay in range
  a_cm_range: assert property (@(posedge clk) disable iff (rst)
    (cm_count <= 9'(MAX_RANGE_CM + 1)) && (sub_cm_count < 6'(US_PER_CM)))
    else $error("centimetre counter out of range");

  // Gap leads only to the back trigger
  a_gap_next: assert property (@(posedge clk) disable iff (rst)
    advance && (phase == PH_GAP) |=> (phase == PH_GAP) || (phase == PH_B_LOW))
    else $error("bad exit from gap");
`endif

endmodule

// File: design/dual_ultrasonic_ranger_top.sv
// Top level of the dual ultrasonic ranger: channel stages and submodules.
//
// Usage: every word on din is one microsecond tick carrying the front and
// back echo levels. For each word exactly one word comes out on dout: the
// trigger levels to drive during that tick, the latest front and back
// distances in cm (999 = no valid echo), the blocked flags and an update
// pulse on the tick that refreshes the flags after a back reading.
// Registers (APB, byte address 4*i): timeout_us, obstacle_cm, gap_us,
// interval_us; write them only while no words are in flight.
// Path: an accepted word is held in the input register and its result in
// the result register. Throughput: one word per cycle while dout is not held;
// the per-tick sequencer step is a single pass of logic between the two.
// Reset (rst, synchronous) empties both stages, loads the register reset
// values and starts at the front trigger low phase with distances of 999.
// Stall: while dout is held, the result register keeps its word and the
// input register takes one more word; then din.ready drops until dout moves.
module dual_ultrasonic_ranger_top
  import dur_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dur_in_if.sink      din,
  dur_out_if.source   dout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  res_t res, res_reg;
  logic in_valid, out_valid, advance;
  logic echo_front, echo_back;

  // Input stage moves on when the result register is free or being read
  assign advance   = in_valid && (!out_valid || dout.ready);
  assign din.ready = !in_valid || advance;

  dur_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dur_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .echo_front (echo_front),
    .echo_back  (echo_back),
    .cfg        (cfg),
    .res        (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      echo_front <= din.echo_front;
      echo_back  <= din.echo_back;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res;
    end
  end

  assign dout.valid         = out_valid;
  assign dout.trig_front    = res_reg.trig_front;
  assign dout.trig_back     = res_reg.trig_back;
  assign dout.front_dist_cm = res_reg.front_dist_cm;
  assign dout.back_cm       = res_reg.back_cm;
  assign dout.front_blocked = res_reg.front_blocked;
  assign dout.back_blocked  = res_reg.back_blocked;
  assign dout.update_done   = res_reg.update_done;

endmodule
